>>> rtl/animation_frame_sequencer_macros.svh
// Assertion macros shared by the sequencer RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ANIMATION_FRAME_SEQUENCER_MACROS_SVH
`define ANIMATION_FRAME_SEQUENCER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AFS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/afs_pkg.sv
// Shared types and constants for the animation frame sequencer.
// No dependencies; imported by the top level and the step engine.
package afs_pkg;

  // Frame counters need one bit more than the 8-bit frame fields.
  localparam int CF_W = 9;

  // Configuration register indexes.
  localparam logic [2:0] REG_FRAME_COUNT  = 3'd0;
  localparam logic [2:0] REG_INTERVAL     = 3'd1;
  localparam logic [2:0] REG_WRAP_HOLD    = 3'd2;
  localparam logic [2:0] REG_SWING        = 3'd3;
  localparam logic [2:0] REG_LOOP_FIRST   = 3'd4;
  localparam logic [2:0] REG_LOOP_LAST    = 3'd5;
  localparam logic [2:0] REG_STOP_FRAME   = 3'd6;
  localparam logic [2:0] REG_REPEAT_TIMES = 3'd7;

  // Request command codes.
  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_WR_DELAY = 2'd1,
    CMD_REWIND   = 2'd2,
    CMD_RESTART  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [8:0]  frame_count;
    logic [31:0] interval;
    logic [31:0] wrap_hold;
    logic        swing;
    logic [7:0]  loop_first;
    logic [7:0]  loop_last;
    logic [7:0]  stop_frame;
    logic [15:0] repeat_times;
  } cfg_t;

endpackage

>>> rtl/afs_delay_mem.sv
// Per-frame extra delay store: one write port, one registered read port.
// Standalone; no package dependencies.
module afs_delay_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold read data until the next read so a stalled step still sees it.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/afs_engine.sv
// Step engine: request capture, playback state, timing arithmetic, result register.
// Depends on afs_pkg and drives the ports of afs_delay_mem.
`include "animation_frame_sequencer_macros.svh"

module afs_engine
  import afs_pkg::*;
#(
  parameter int MAX_FRAMES = 256,
  parameter int TIME_BITS  = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cfg_t                          cfg,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_command,
  input  logic [31:0]                   in_amount,
  input  logic [7:0]                    in_frame_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_frame,
  output logic                          out_frame_changed,
  output logic                          out_play_end,
  output logic                          out_ended,
  output logic                          rd_en,
  output logic [$clog2(MAX_FRAMES)-1:0] rd_addr,
  input  logic [TIME_BITS-1:0]          rd_data,
  output logic                          wr_en,
  output logic [$clog2(MAX_FRAMES)-1:0] wr_addr,
  output logic [TIME_BITS-1:0]          wr_data
);

  localparam int AW   = $clog2(MAX_FRAMES);
  localparam int AXW  = (AW > CF_W) ? AW : CF_W;
  localparam int IW   = (AW > 8) ? AW : 8;
  localparam int NCAP = (MAX_FRAMES < 511) ? MAX_FRAMES : 511;
  localparam int TXW  = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam int ETW  = TIME_BITS + 1;
  localparam int SW   = TIME_BITS + 2;

  typedef enum logic [1:0] {
    ST_PLAY      = 2'd0,
    ST_TO_START  = 2'd1,
    ST_TO_END_AT = 2'd2,
    ST_ENDED     = 2'd3
  } st_t;

  function automatic logic [CF_W-1:0] clamp_last(input logic [CF_W-1:0] v,
                                                 input logic [CF_W-1:0] last);
    return (v > last) ? last : v;
  endfunction

  // Playback state
  logic [CF_W-1:0]      cf_r, cf_nxt;
  logic [ETW-1:0]       el_r, el_nxt;
  logic                 rev_r, rev_nxt;
  logic                 wrap_r, wrap_nxt;
  st_t                  st_r, st_nxt;
  logic [15:0]          rep_r, rep_nxt;

  // Captured request
  logic                 s1_vld_r;
  cmd_t                 s1_cmd_r;
  logic [TIME_BITS-1:0] s1_amt_r;
  logic [7:0]           s1_idx_r;
  logic [CF_W-1:0]      s1_cf_r;
  logic [ETW-1:0]       s1_sum_r;
  logic [SW-1:0]        s1_base_r;

  // Result register
  logic                 out_vld_r;
  logic [7:0]           out_frame_r;
  logic                 out_changed_r;
  logic                 out_play_end_r;
  logic                 out_ended_r;

  logic                 accept;
  logic                 go;
  logic                 tick_live;
  logic [CF_W-1:0]      n, nm1;
  logic [CF_W-1:0]      start_cl, end_cl, endat_cl;
  logic [TIME_BITS-1:0] interval_t, rdelay_t, amt_t;
  logic [CF_W-1:0]      cf_cl;
  logic [SW-1:0]        sum_full;
  logic [SW-1:0]        base;
  logic [SW-1:0]        ft;
  logic [SW:0]          diff;
  logic                 reached;
  logic [ETW-1:0]       rem_el;
  logic [CF_W-1:0]      adv_cf;
  logic                 adv_rev, adv_wrap;
  logic                 changed, pend;

  assign accept   = in_valid && !in_stall;
  assign go       = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = s1_vld_r;

  // Clip length and clamped frame settings
  assign n        = (cfg.frame_count > CF_W'(NCAP)) ? CF_W'(NCAP) : cfg.frame_count;
  assign nm1      = n - 1'b1;
  assign start_cl = clamp_last({1'b0, cfg.loop_first}, nm1);
  assign end_cl   = clamp_last({1'b0, cfg.loop_last}, nm1);
  assign endat_cl = clamp_last({1'b0, cfg.stop_frame}, nm1);

  assign interval_t = TIME_BITS'(TXW'(cfg.interval));
  assign rdelay_t   = TIME_BITS'(TXW'(cfg.wrap_hold));
  assign amt_t      = TIME_BITS'(TXW'(in_amount));

  // Capture side: accumulate and form the fixed part of the frame time
  assign cf_cl    = clamp_last(cf_r, nm1);
  assign sum_full = SW'(el_r) + SW'(amt_t);
  assign base     = SW'(interval_t) +
                    ((cf_cl == '0 && wrap_r) ? SW'(rdelay_t) : SW'(0));

  assign rd_en   = accept;
  assign rd_addr = AW'(AXW'(cf_cl));

  // Step side: frame time compare and remainder
  assign ft      = s1_base_r + SW'(rd_data);
  assign diff    = (SW + 1)'(s1_sum_r) - (SW + 1)'(ft);
  assign reached = !diff[SW];
  assign rem_el  = (diff[ETW-1:0] > ETW'(interval_t)) ? ETW'(interval_t) : diff[ETW-1:0];

  assign wr_en   = go && (s1_cmd_r == CMD_WR_DELAY) &&
                   ({1'b0, IW'(s1_idx_r)} < (IW + 1)'(MAX_FRAMES));
  assign wr_addr = AW'(IW'(s1_idx_r));
  assign wr_data = s1_amt_r;

  assign tick_live = (s1_cmd_r == CMD_TICK) && n != '0 && st_r != ST_ENDED;

  // One frame step, wrap or ping-pong
  always_comb begin
    adv_cf   = s1_cf_r;
    adv_rev  = rev_r;
    adv_wrap = wrap_r;
    if (cfg.swing) begin
      if (rev_r) begin
        if (s1_cf_r <= CF_W'(1)) begin
          adv_cf   = '0;
          adv_wrap = 1'b1;
          adv_rev  = 1'b0;
        end else begin
          adv_cf = s1_cf_r - 1'b1;
        end
      end else if (s1_cf_r >= nm1) begin
        adv_cf   = (n >= CF_W'(2)) ? n - CF_W'(2) : '0;
        adv_wrap = 1'b1;
        adv_rev  = 1'b1;
      end else begin
        adv_cf = s1_cf_r + 1'b1;
      end
    end else if (s1_cf_r >= nm1) begin
      adv_cf   = '0;
      adv_wrap = 1'b1;
    end else begin
      adv_cf = s1_cf_r + 1'b1;
    end
  end

  always_comb begin
    cf_nxt   = cf_r;
    el_nxt   = el_r;
    rev_nxt  = rev_r;
    wrap_nxt = wrap_r;
    st_nxt   = st_r;
    rep_nxt  = rep_r;
    changed  = 1'b0;
    pend     = 1'b0;
    case (s1_cmd_r)
      CMD_TICK: begin
        if (n != '0 && st_r != ST_ENDED) begin
          cf_nxt = s1_cf_r;
          el_nxt = s1_sum_r;
          if (reached) begin
            el_nxt   = rem_el;
            cf_nxt   = adv_cf;
            rev_nxt  = adv_rev;
            wrap_nxt = adv_wrap;
            changed  = 1'b1;
            case (st_r)
              ST_TO_START: begin
                cf_nxt = start_cl;
                el_nxt = '0;
                st_nxt = ST_PLAY;
              end
              ST_TO_END_AT: begin
                cf_nxt = endat_cl;
                el_nxt = '0;
                st_nxt = ST_ENDED;
                pend   = 1'b1;
              end
              default: begin
                if (adv_cf == end_cl) begin
                  if (rep_r != '0) begin
                    rep_nxt = rep_r - 1'b1;
                    st_nxt  = (rep_r == 16'd1) ? ST_TO_END_AT : ST_TO_START;
                  end else if (start_cl != '0) begin
                    st_nxt = ST_TO_START;
                  end
                end
              end
            endcase
          end
        end
      end
      CMD_WR_DELAY: begin
      end
      CMD_REWIND: begin
        cf_nxt   = '0;
        el_nxt   = '0;
        rev_nxt  = 1'b0;
        wrap_nxt = 1'b0;
        st_nxt   = ST_PLAY;
        changed  = 1'b1;
      end
      default: begin
        rep_nxt = cfg.repeat_times;
        st_nxt  = ST_PLAY;
        if (n == '0) begin
          cf_nxt = {1'b0, cfg.loop_first};
        end else begin
          cf_nxt  = start_cl;
          el_nxt  = '0;
          changed = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cf_r      <= '0;
      el_r      <= '0;
      rev_r     <= 1'b0;
      wrap_r    <= 1'b0;
      st_r      <= ST_PLAY;
      rep_r     <= '0;
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_vld_r  <= 1'b1;
        s1_cmd_r  <= cmd_t'(in_command);
        s1_amt_r  <= amt_t;
        s1_idx_r  <= in_frame_index;
        s1_cf_r   <= cf_cl;
        s1_sum_r  <= sum_full[SW-1] ? {ETW{1'b1}} : sum_full[ETW-1:0];
        s1_base_r <= base;
      end else if (go) begin
        s1_vld_r <= 1'b0;
      end
      if (go) begin
        cf_r           <= cf_nxt;
        el_r           <= el_nxt;
        rev_r          <= rev_nxt;
        wrap_r         <= wrap_nxt;
        st_r           <= st_nxt;
        rep_r          <= rep_nxt;
        out_vld_r      <= 1'b1;
        out_frame_r    <= cf_nxt[7:0];
        out_changed_r  <= changed;
        out_play_end_r <= pend;
        out_ended_r    <= (st_nxt == ST_ENDED);
      end else if (out_vld_r && !out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_vld_r;
  assign out_frame         = out_frame_r;
  assign out_frame_changed = out_changed_r;
  assign out_play_end      = out_play_end_r;
  assign out_ended         = out_ended_r;

  `AFS_ASSERT_NEXT(a_accept_spacing, accept, in_stall, "request accepted on consecutive cycles")
  `AFS_ASSERT_NOW(a_mem_port_excl, wr_en, !rd_en, "delay write collides with a read")
  `AFS_ASSERT_NOW(a_pend_ended, out_vld_r && out_play_end_r, out_ended_r, "play end without end")
  `AFS_ASSERT_NEXT(a_frame_in_clip, go && tick_live, cf_r <= $past(nm1), "frame outside clip")

endmodule

>>> rtl/animation_frame_sequencer.sv
// Top level of the animation frame sequencer: configuration registers and wiring.
// Depends on afs_pkg, afs_delay_mem and afs_engine.
//
// Sprite animation sequencer. Each request is a tick (elapsed time, already
// scaled), a per-frame delay write, a rewind or a restart; each request yields
// exactly one result with the frame index, a frame-changed flag, a play-end
// pulse and the ended flag. The current frame addresses the per-frame delay
// memory in the cycle the request is accepted, and the registered read data
// closes the frame-time compare and state update when the step goes ahead, so
// in_stall rises after every accepted request until that step is done. Results
// sit in an output register, so a new request is taken while an earlier result
// still waits on out_stall; the block only stalls longer when that register is
// full and held. The delay memory has no reset and needs no clearing pass:
// an entry must be written before the frame it belongs to is played.
// Configuration writes take effect at once and belong to idle periods only.
module animation_frame_sequencer
  import afs_pkg::*;
#(
  parameter int MAX_FRAMES = 256,
  parameter int TIME_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_amount,
  input  logic [7:0]  in_frame_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_frame,
  output logic        out_frame_changed,
  output logic        out_play_end,
  output logic        out_ended
);

  localparam int AW = $clog2(MAX_FRAMES);

  cfg_t                 cfg_r;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [TIME_BITS-1:0] rd_data;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [TIME_BITS-1:0] wr_data;

  // Register file: truncate each write to the field width; end frames reset to 255
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_count  <= '0;
      cfg_r.interval     <= '0;
      cfg_r.wrap_hold    <= '0;
      cfg_r.swing        <= 1'b0;
      cfg_r.loop_first   <= '0;
      cfg_r.loop_last    <= 8'd255;
      cfg_r.stop_frame   <= 8'd255;
      cfg_r.repeat_times <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FRAME_COUNT:  cfg_r.frame_count  <= cfg_wdata[8:0];
        REG_INTERVAL:     cfg_r.interval     <= cfg_wdata;
        REG_WRAP_HOLD:    cfg_r.wrap_hold    <= cfg_wdata;
        REG_SWING:        cfg_r.swing        <= cfg_wdata[0];
        REG_LOOP_FIRST:   cfg_r.loop_first   <= cfg_wdata[7:0];
        REG_LOOP_LAST:    cfg_r.loop_last    <= cfg_wdata[7:0];
        REG_STOP_FRAME:   cfg_r.stop_frame   <= cfg_wdata[7:0];
        REG_REPEAT_TIMES: cfg_r.repeat_times <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // Per-frame extra delays, read at request accept, written on delay requests
  afs_delay_mem #(
    .DEPTH(MAX_FRAMES),
    .WIDTH(TIME_BITS)
  ) u_delay_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Playback state, timing and the result register
  afs_engine #(
    .MAX_FRAMES(MAX_FRAMES),
    .TIME_BITS (TIME_BITS)
  ) u_engine (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_amount        (in_amount),
    .in_frame_index   (in_frame_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame        (out_frame),
    .out_frame_changed(out_frame_changed),
    .out_play_end     (out_play_end),
    .out_ended        (out_ended),
    .rd_en            (rd_en),
    .rd_addr          (rd_addr),
    .rd_data          (rd_data),
    .wr_en            (wr_en),
    .wr_addr          (wr_addr),
    .wr_data          (wr_data)
  );

endmodule
